// File: rtl/etc1_pkg.sv
// Package with the shared constant tables of the ETC1 block decoder.
`default_nettype none

package etc1_pkg;

  // Pixels in a block and the width of the in-block pixel counter.
  localparam int unsigned NUM_PIXELS = 16;
  localparam int unsigned PIX_W      = 4;

  typedef logic signed [8:0] modifier_t;
  typedef logic [PIX_W-1:0]  pix_idx_t;

  // Standard ETC1 intensity modifiers, one row per table code, one column per selector.
  localparam modifier_t INTENSITY_TAB [8][4] = '{
    '{ 9'sd2,  9'sd8,   -9'sd2,  -9'sd8   },
    '{ 9'sd5,  9'sd17,  -9'sd5,  -9'sd17  },
    '{ 9'sd9,  9'sd29,  -9'sd9,  -9'sd29  },
    '{ 9'sd13, 9'sd42,  -9'sd13, -9'sd42  },
    '{ 9'sd18, 9'sd60,  -9'sd18, -9'sd60  },
    '{ 9'sd24, 9'sd80,  -9'sd24, -9'sd80  },
    '{ 9'sd33, 9'sd106, -9'sd33, -9'sd106 },
    '{ 9'sd47, 9'sd183, -9'sd47, -9'sd183 }
  };

  // Output order: 2x2 Morton walk over the pixel index p = 4*x + y.
  localparam pix_idx_t MORTON_SEQ [NUM_PIXELS] = '{
    4'd0, 4'd4, 4'd1, 4'd5, 4'd8, 4'd12, 4'd9, 4'd13,
    4'd2, 4'd6, 4'd3, 4'd7, 4'd10, 4'd14, 4'd11, 4'd15
  };

endpackage

`default_nettype wire

// File: rtl/etc1_block_decoder.sv
// ETC1 block decoder with optional 4-bit alpha; one RGBA pixel per unstalled cycle.
//
// Usage: the input channel (in_valid / in_stall) carries one item per 4x4 block:
// a 64-bit ETC1 color word and a 64-bit alpha word with one nibble per pixel.
// The output channel (out_valid / out_stall) carries sixteen items per block,
// one per pixel, in 2x2 Morton order, with the pixel's column and row and a
// last_pixel flag on the sixteenth. The configuration channel (cfg_valid /
// cfg_ready / cfg_data) writes the alpha_present bit; it is always ready and
// should only be written while no block is in flight.
//
// An accepted block is held in the block register, and its pixels are decoded
// by a single pixel decoder that feeds the output register once per cycle
// while the receiver does not stall. The next block is accepted in the cycle
// in which the last pixel of the current one moves into the output register,
// so blocks stream with no gap.
//
// Reset (synchronous, rst_n low) empties the block and output registers and
// clears alpha_present. When the receiver stalls, the output register holds
// its pixel, the pixel counter stops, and in_stall is raised once a block is
// waiting.
`default_nettype none

module etc1_block_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Block input channel.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_alpha_word,
  input  wire logic [63:0] in_color_word,
  // Pixel output channel.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha,
  output logic [1:0]       out_pixel_x,
  output logic [1:0]       out_pixel_y,
  output logic             out_last_pixel,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);

  // Configuration register.
  logic alpha_present_r;

  // Block register and the pixel counter that walks it.
  logic                   blk_valid_r, blk_valid_nxt;
  logic [63:0]            color_r;
  logic [63:0]            alpha_word_r;
  etc1_pkg::pix_idx_t     k_r, k_nxt;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             red_r, green_r, blue_r, alpha_r;
  logic [1:0]             pixel_x_r, pixel_y_r;
  logic                   last_r;

  // Handshake terms.
  logic out_free;     // the output register can take a pixel this cycle
  logic advance;      // a pixel moves from the decoder to the output register
  logic last_k;
  logic in_take;

  // Decoder signals.
  etc1_pkg::pix_idx_t   p;
  logic [7:0]           ch [3];
  logic [7:0]           base0 [3];
  logic [7:0]           base1 [3];
  logic                 flip, diff, second;
  logic [2:0]           tab0, tab1, tab_sel;
  logic [1:0]           sel;
  etc1_pkg::modifier_t  modv;
  logic [7:0]           pix [3];
  logic [3:0]           a_nib;
  logic [7:0]           a_val;

  assign cfg_ready = 1'b1;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = blk_valid_r && out_free;
  assign last_k   = (k_r == etc1_pkg::pix_idx_t'(etc1_pkg::NUM_PIXELS - 1));
  // A new block may enter when none is held or the held one is finishing now.
  assign in_stall = blk_valid_r && !(advance && last_k);
  assign in_take  = in_valid && !in_stall;

  // Base colors. Individual mode replicates each nibble; differential mode
  // adds a signed 3-bit delta modulo 256 and expands 5 bits to 8.
  assign flip = color_r[32];
  assign diff = color_r[33];
  assign tab1 = color_r[36:34];
  assign tab0 = color_r[39:37];
  assign ch[0] = color_r[63:56];
  assign ch[1] = color_r[55:48];
  assign ch[2] = color_r[47:40];

  always_comb begin
    logic [7:0] b1;
    b1 = 8'd0;
    for (int c = 0; c < 3; c++) begin
      b1 = {3'b000, ch[c][7:3]} + {{5{ch[c][2]}}, ch[c][2:0]};
      if (diff) begin
        base0[c] = {ch[c][7:3], ch[c][7:5]};
        // A wrapped base also ORs the sum's top bits into bits 5:3 of the result.
        base1[c] = {b1[4:0], 3'b000} | {2'b00, b1[7:2]};
      end else begin
        base0[c] = {ch[c][7:4], ch[c][7:4]};
        base1[c] = {ch[c][3:0], ch[c][3:0]};
      end
    end
  end

  // Per-pixel selection of sub-block, table and modifier.
  assign p       = etc1_pkg::MORTON_SEQ[k_r];
  assign second  = flip ? p[1] : p[3];
  assign tab_sel = second ? tab1 : tab0;
  assign sel     = {color_r[16 + p], color_r[p]};
  assign modv    = etc1_pkg::INTENSITY_TAB[tab_sel][sel];

  always_comb begin
    logic signed [9:0] sum;
    sum = 10'sd0;
    for (int c = 0; c < 3; c++) begin
      sum = $signed({2'b00, (second ? base1[c] : base0[c])}) + $signed({modv[8], modv});
      if (sum < 0) begin
        pix[c] = 8'd0;
      end else if (sum > 10'sd255) begin
        pix[c] = 8'd255;
      end else begin
        pix[c] = sum[7:0];
      end
    end
  end

  assign a_nib = alpha_word_r[{p, 2'b00} +: 4];
  assign a_val = alpha_present_r ? {a_nib, a_nib} : 8'hFF;

  // Next-state logic for the block and output registers.
  always_comb begin
    blk_valid_nxt = blk_valid_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = blk_valid_r;
    end
    if (advance) begin
      k_nxt = k_r + 1'b1;
      if (last_k) begin
        blk_valid_nxt = 1'b0;
      end
    end
    if (in_take) begin
      blk_valid_nxt = 1'b1;
      k_nxt         = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_present_r <= 1'b0;
      blk_valid_r     <= 1'b0;
      out_valid_r     <= 1'b0;
      k_r             <= '0;
    end else begin
      blk_valid_r <= blk_valid_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      if (cfg_valid && cfg_ready) begin
        alpha_present_r <= cfg_data;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      color_r      <= in_color_word;
      alpha_word_r <= in_alpha_word;
    end
    if (advance) begin
      red_r     <= pix[0];
      green_r   <= pix[1];
      blue_r    <= pix[2];
      alpha_r   <= a_val;
      pixel_x_r <= p[3:2];
      pixel_y_r <= p[1:0];
      last_r    <= last_k;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_alpha      = alpha_r;
  assign out_pixel_x    = pixel_x_r;
  assign out_pixel_y    = pixel_y_r;
  assign out_last_pixel = last_r;

endmodule

`default_nettype wire
